FILE: sv/bitmap_glyph_text_renderer_macros.svh
// Assertion macros for the bitmap glyph text renderer.
`ifndef BITMAP_GLYPH_TEXT_RENDERER_MACROS_SVH
`define BITMAP_GLYPH_TEXT_RENDERER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BGTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define BGTR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/bgtr_pkg.sv
// Types and constants shared by the bitmap glyph text renderer files.
package bgtr_pkg;

    localparam int GLYPH_WIDTH    = 8;
    localparam int MAX_GLYPH_ROWS = 32;
    localparam int GLYPH_SLOTS    = 512;
    localparam int ROW_W          = $clog2(MAX_GLYPH_ROWS);
    localparam int CODE_W         = $clog2(GLYPH_SLOTS);
    localparam int STORE_DEPTH    = GLYPH_SLOTS * MAX_GLYPH_ROWS;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int HEIGHT_W       = 6;
    localparam int CURSOR_W       = 16;
    localparam int COLOR_W        = 24;

    typedef enum logic [1:0] {
        OP_DRAW    = 2'd0,
        OP_NEWLINE = 2'd1,
        OP_LOAD    = 2'd2,
        OP_HOME    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_FG_COLOR   = 3'd0,
        CFG_BG_COLOR   = 3'd1,
        CFG_HEIGHT     = 3'd2,
        CFG_COUNT_512  = 3'd3,
        CFG_SCR_WIDTH  = 3'd4,
        CFG_SCR_HEIGHT = 3'd5,
        CFG_PITCH      = 3'd6,
        CFG_PIX_BYTES  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DRAW
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [8:0] char_code;
        logic [4:0] row_index;
        logic [7:0] row_bits;
    } t_in;

    typedef struct packed {
        logic [31:0]        byte_offset;
        logic [7:0]         in_bounds_mask;
        logic [COLOR_W-1:0] pixel_0;
        logic [COLOR_W-1:0] pixel_1;
        logic [COLOR_W-1:0] pixel_2;
        logic [COLOR_W-1:0] pixel_3;
        logic [COLOR_W-1:0] pixel_4;
        logic [COLOR_W-1:0] pixel_5;
        logic [COLOR_W-1:0] pixel_6;
        logic [COLOR_W-1:0] pixel_7;
        logic               last_row;
    } t_out;

endpackage

FILE: sv/bgtr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bgtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: sv/bitmap_glyph_text_renderer.sv
// Top level of the bitmap glyph text renderer: 8-pixel-wide console character generator.
//
// Usage
//  - Input channel (i_in_valid/o_in_ready, i_in_data): one command per transfer.
//    Load writes one glyph scanline, newline and home move the cursor; none of
//    these gives a result.
//  - Draw gives one result per glyph scanline on the output channel
//    (o_out_valid/i_out_ready, o_out_data), last_row set on the final one.
//  - A draw passes through the accept in idle, the setup state (offset multiply
//    and cursor advance), a store read per scanline and the output register;
//    the store read port sets the pace. At height zero no scanline is drawn.
//  - Commands are taken one at a time; a new one is accepted once the last
//    scanline of the previous draw has reached the output register.
//  - Configuration port (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) is
//    always ready; write it only while the block is idle.
//  - Reset (synchronous, active low) restores register defaults, homes the
//    cursor and empties the output stage. The glyph store is not cleared and
//    must be loaded before use.
//  - When the receiver stalls the result is held in the output register, one
//    further scanline waits in the store read register and reads pause.
module bitmap_glyph_text_renderer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bgtr_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bgtr_pkg::t_out     o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    // configuration
    logic [bgtr_pkg::COLOR_W-1:0] r_fg;
    logic [bgtr_pkg::COLOR_W-1:0] r_bg;
    logic [5:0]                   r_cfg_height;
    logic                         r_count_512;
    logic [12:0]                  r_scr_w;
    logic [12:0]                  r_scr_h;
    logic [14:0]                  r_pitch;
    logic [2:0]                   r_pix_bytes;

    // cursor and sequencing
    bgtr_pkg::t_state                  r_state, n_state;
    logic [bgtr_pkg::CURSOR_W-1:0]     r_col, r_row;
    logic [bgtr_pkg::CODE_W-1:0]       r_code;
    logic [bgtr_pkg::HEIGHT_W-1:0]     r_h;
    logic [bgtr_pkg::HEIGHT_W-1:0]     r_y;
    logic [16:0]                       r_py;
    logic [31:0]                       r_off;
    logic [7:0]                        r_col_mask;

    // scanline waiting in the store read register
    logic        r_pend;
    logic [31:0] r_p_off;
    logic        r_p_row_ok;
    logic        r_p_last;

    logic           r_out_valid;
    bgtr_pkg::t_out r_out;

    logic                            w_in_xfer;
    logic                            w_wr_en;
    logic [bgtr_pkg::STORE_AW-1:0]   w_wr_addr;
    logic [bgtr_pkg::STORE_AW-1:0]   w_rd_addr;
    logic [7:0]                      w_glyph;
    logic                            w_load;
    logic                            w_issue;
    logic                            w_draw_done;
    logic [bgtr_pkg::HEIGHT_W-1:0]   w_h_eff;
    logic                            w_pb4;
    logic [bgtr_pkg::CODE_W-1:0]     w_code_map;
    logic [17:0]                     w_col_bytes;
    logic [30:0]                     w_row_bytes;
    logic [bgtr_pkg::CURSOR_W-1:0]   w_col_adv;
    logic                            w_wrap;
    logic [7:0]                      w_col_mask;
    logic [16:0]                     w_col_i;
    logic [bgtr_pkg::COLOR_W-1:0]    w_pix [8];

    // effective height saturates at the store row count; pixel bytes clamp to 3..4
    assign w_h_eff = (r_cfg_height > 6'(bgtr_pkg::MAX_GLYPH_ROWS))
                   ? 6'(bgtr_pkg::MAX_GLYPH_ROWS) : r_cfg_height;
    assign w_pb4   = (r_pix_bytes >= 3'd4);

    // codes beyond the active glyph count draw glyph 0
    assign w_code_map = (!r_count_512 && i_in_data.char_code[8]) ? '0 : i_in_data.char_code;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == bgtr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // glyph store: loads in idle, scanline reads while drawing
    assign w_wr_en   = w_in_xfer && (i_in_data.operation == bgtr_pkg::OP_LOAD);
    assign w_wr_addr = {i_in_data.char_code, i_in_data.row_index};
    assign w_rd_addr = {r_code, r_y[bgtr_pkg::ROW_W-1:0]};

    bgtr_ram #(
        .WIDTH (8),
        .DEPTH (bgtr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in_data.row_bits),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_glyph)
    );

    // output register takes the waiting scanline when it is empty or draining
    assign w_load  = r_pend && (!r_out_valid || i_out_ready);
    // a new read may overwrite the read register only once its scanline moves on
    assign w_issue = (r_state == bgtr_pkg::S_DRAW) && (r_y != r_h) && (!r_pend || w_load);
    assign w_draw_done = (r_y == r_h) && (!r_pend || w_load);

    // setup-cycle arithmetic on the cursor before it advances
    assign w_col_bytes = w_pb4 ? {r_col, 2'b00} : ({1'b0, r_col, 1'b0} + {2'b00, r_col});
    assign w_row_bytes = r_row * r_pitch;
    assign w_col_adv   = r_col + 16'(bgtr_pkg::GLYPH_WIDTH);
    assign w_wrap      = ({1'b0, w_col_adv} + 17'(bgtr_pkg::GLYPH_WIDTH)) > {4'b0, r_scr_w};

    always_comb begin
        w_col_mask = '0;
        w_col_i    = '0;
        for (int i = 0; i < 8; i++) begin
            w_col_i       = {1'b0, r_col} + 17'(i);
            w_col_mask[i] = w_col_i < {4'b0, r_scr_w};
        end
    end

    // MSB of the scanline is the leftmost pixel
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_pix[i] = w_glyph[7 - i] ? r_fg : r_bg;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bgtr_pkg::S_IDLE: begin
                if (w_in_xfer && (i_in_data.operation == bgtr_pkg::OP_DRAW)) begin
                    n_state = bgtr_pkg::S_SETUP;
                end
            end
            bgtr_pkg::S_SETUP: begin
                n_state = (w_h_eff == '0) ? bgtr_pkg::S_IDLE : bgtr_pkg::S_DRAW;
            end
            bgtr_pkg::S_DRAW: begin
                if (w_draw_done) begin
                    n_state = bgtr_pkg::S_IDLE;
                end
            end
            default: n_state = bgtr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bgtr_pkg::S_IDLE;
            r_fg         <= 24'hFFFFFF;
            r_bg         <= '0;
            r_cfg_height <= 6'd16;
            r_count_512  <= 1'b0;
            r_scr_w      <= 13'd1024;
            r_scr_h      <= 13'd768;
            r_pitch      <= 15'd4096;
            r_pix_bytes  <= 3'd4;
            r_col        <= '0;
            r_row        <= '0;
            r_h          <= '0;
            r_y          <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (bgtr_pkg::t_cfg_idx'(i_cfg_index))
                    bgtr_pkg::CFG_FG_COLOR:   r_fg         <= i_cfg_data;
                    bgtr_pkg::CFG_BG_COLOR:   r_bg         <= i_cfg_data;
                    bgtr_pkg::CFG_HEIGHT:     r_cfg_height <= i_cfg_data[5:0];
                    bgtr_pkg::CFG_COUNT_512:  r_count_512  <= i_cfg_data[0];
                    bgtr_pkg::CFG_SCR_WIDTH:  r_scr_w      <= i_cfg_data[12:0];
                    bgtr_pkg::CFG_SCR_HEIGHT: r_scr_h      <= i_cfg_data[12:0];
                    bgtr_pkg::CFG_PITCH:      r_pitch      <= i_cfg_data[14:0];
                    bgtr_pkg::CFG_PIX_BYTES:  r_pix_bytes  <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (w_in_xfer) begin
                case (bgtr_pkg::t_op'(i_in_data.operation))
                    bgtr_pkg::OP_NEWLINE: begin
                        r_col <= '0;
                        r_row <= r_row + 16'(w_h_eff);
                    end
                    bgtr_pkg::OP_HOME: begin
                        r_col <= '0;
                        r_row <= '0;
                    end
                    bgtr_pkg::OP_DRAW: begin
                        r_code <= w_code_map;
                    end
                    default: ;
                endcase
            end

            // setup: base offset, clip mask and cursor advance from the old cursor
            if (r_state == bgtr_pkg::S_SETUP) begin
                r_off      <= 32'(w_row_bytes) + 32'(w_col_bytes);
                r_py       <= {1'b0, r_row};
                r_col_mask <= w_col_mask;
                r_h        <= w_h_eff;
                r_y        <= '0;
                if (w_wrap) begin
                    r_col <= '0;
                    r_row <= r_row + 16'(w_h_eff);
                end else begin
                    r_col <= w_col_adv;
                end
            end

            if (w_issue) begin
                r_p_off    <= r_off;
                r_p_row_ok <= r_py < {4'b0, r_scr_h};
                r_p_last   <= (r_y + 6'd1) == r_h;
                r_off      <= r_off + 32'(r_pitch);
                r_py       <= r_py + 17'd1;
                r_y        <= r_y + 6'd1;
            end

            if (w_issue) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.byte_offset    <= r_p_off;
            r_out.in_bounds_mask <= r_p_row_ok ? r_col_mask : 8'h00;
            r_out.pixel_0        <= w_pix[0];
            r_out.pixel_1        <= w_pix[1];
            r_out.pixel_2        <= w_pix[2];
            r_out.pixel_3        <= w_pix[3];
            r_out.pixel_4        <= w_pix[4];
            r_out.pixel_5        <= w_pix[5];
            r_out.pixel_6        <= w_pix[6];
            r_out.pixel_7        <= w_pix[7];
            r_out.last_row       <= r_p_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "bitmap_glyph_text_renderer_macros.svh"

    `BGTR_ASSERT(a_pend_in_draw, r_pend |-> (r_state == bgtr_pkg::S_DRAW), "scanline pending outside draw")
    `BGTR_ASSERT(a_y_bound, (r_state == bgtr_pkg::S_DRAW) |-> (r_y <= r_h), "scanline count overran height")
    `BGTR_NEVER(a_rw_clash, w_wr_en && w_issue, "glyph load collided with scanline read")
    `BGTR_ASSERT(a_no_overwrite, (r_pend && !w_load) |-> !w_issue, "read overwrote a waiting scanline")

endmodule
